// ===== sv/afso_pkg.sv =====
// shared types and constants for the array flag split offset block
package afso_pkg;

  localparam int unsigned LenBits   = 32;
  localparam int unsigned ValueBits = 32;
  localparam int unsigned RowBits   = 32;
  localparam int unsigned MaxRes    = 3;
  localparam int unsigned CntBits   = 2;

  // apb register map
  localparam int unsigned PaddrBits = 3;
  localparam int unsigned PdataBits = 32;
  localparam logic        REG_REVERSE_MODE = 1'b0;

  // action codes of an input item
  localparam logic ACT_HEADER  = 1'b0;
  localparam logic ACT_ELEMENT = 1'b1;

  typedef enum logic [1:0] {
    KIND_INNER = 2'd0,
    KIND_OUTER = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef struct packed {
    logic               action;
    logic [LenBits-1:0] src_len;
    logic [LenBits-1:0] split_len;
    logic               row_null;
    logic               cut_flag;
    logic               cut_null;
  } in_item_t;

  typedef struct packed {
    kind_e                kind;
    logic [ValueBits-1:0] value;
    logic                 last;
  } result_t;

  // all results caused by one item, slot 0 first
  typedef struct packed {
    logic [CntBits-1:0]       count;
    result_t [MaxRes-1:0]     res;
  } group_t;

  typedef struct packed {
    logic err;
  } core_stat_t;

  typedef struct packed {
    logic               ready;
    logic [CntBits-1:0] pending;
  } emit_stat_t;

endpackage

// ===== sv/afso_in_if.sv =====
// input item channel
interface afso_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [afso_pkg::LenBits-1:0]  src_len;
  logic [afso_pkg::LenBits-1:0]  split_len;
  logic                          row_null;
  logic                          cut_flag;
  logic                          cut_null;

  modport source (output valid, action, src_len, split_len, row_null, cut_flag, cut_null,
                  input ready);
  modport sink (input valid, action, src_len, split_len, row_null, cut_flag, cut_null,
                output ready);
endinterface

// ===== sv/afso_out_if.sv =====
// result item channel
interface afso_out_if;
  logic                            valid;
  logic                            ready;
  afso_pkg::kind_e                 kind;
  logic [afso_pkg::ValueBits-1:0]  value;
  logic                            last;

  modport source (output valid, kind, value, last, input ready);
  modport sink (input valid, kind, value, last, output ready);
endinterface

// ===== sv/array_flag_split_offsets.sv =====
// top level of the array flag split offset generator
//
//   port    dir   protocol       carries
//   in_i    in    valid/ready    row header or one array element
//   out_o   out   valid/ready    inner offset, outer offset or length error
//   apb     in    apb write/read reverse_mode at byte address 0
//
// every item is accepted in a single handshake and leaves 0 to 3 results; one result
// goes out per cycle while the output is ready, so throughput is one item per cycle
// while items give at most one result each; a larger group holds the input until its
// last result is taken; each result passes the group register, then the output register.
// reset clears all row state and the sticky error; after an uneven length
// error, items are still accepted but give no results until reset.
// a stalled output holds its item; the input accepts only while the group slot is free.
module array_flag_split_offsets #(
  parameter int unsigned POS_BITS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  afso_in_if.sink                            in_i,
  afso_out_if.source                         out_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [afso_pkg::PaddrBits-1:0]     paddr,
  input  logic [afso_pkg::PdataBits-1:0]     pwdata,
  output logic [afso_pkg::PdataBits-1:0]     prdata,
  output logic                               pready
);
  import afso_pkg::*;

  logic       reverse_q;
  logic       fire;
  logic       reg_sel;
  in_item_t   item;
  group_t     grp;
  core_stat_t core_stat;
  emit_stat_t emit_stat;

  // configuration register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[PaddrBits-1] == REG_REVERSE_MODE);
  assign prdata  = reg_sel ? PdataBits'(reverse_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reverse_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      reverse_q <= pwdata[0];
    end
  end

  // input handshake
  assign in_i.ready = emit_stat.ready;
  assign fire       = in_i.valid && emit_stat.ready;

  assign item.action    = in_i.action;
  assign item.src_len   = in_i.src_len;
  assign item.split_len = in_i.split_len;
  assign item.row_null  = in_i.row_null;
  assign item.cut_flag  = in_i.cut_flag;
  assign item.cut_null  = in_i.cut_null;

  afso_core #(
    .POS_BITS(POS_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .reverse_mode_i(reverse_q),
    .fire_i        (fire),
    .item_i        (item),
    .group_o       (grp),
    .stat_o        (core_stat)
  );

  afso_emit u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (fire),
    .group_i(grp),
    .stat_o (emit_stat),
    .out_o  (out_o)
  );

  // once set, the error stays until reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_stat.err |=> core_stat.err)
    else $error("sticky error cleared");

  // after an error no item makes results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && core_stat.err) |-> (grp.count == '0))
    else $error("results after sticky error");

  // a loaded group is fully pending in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (grp.count != '0)) |=> (emit_stat.pending == $past(grp.count)))
    else $error("result group lost or overwritten");

  // an error is always the only and final result of its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.kind == KIND_ERROR)) |-> out_o.last)
    else $error("error result without last");

endmodule

// ===== sv/afso_core.sv =====
// row and element state, computes the result group of each accepted item
module afso_core #(
  parameter int unsigned POS_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                reverse_mode_i,
  input  logic                fire_i,
  input  afso_pkg::in_item_t  item_i,
  output afso_pkg::group_t    group_o,
  output afso_pkg::core_stat_t stat_o
);
  import afso_pkg::*;

  logic [POS_BITS-1:0] pos_q, pos_d;
  logic [POS_BITS-1:0] row_start_q, row_start_d;
  logic [POS_BITS-1:0] row_end_q, row_end_d;
  logic [POS_BITS-1:0] inner_q, inner_d;
  logic [RowBits-1:0]  row_cnt_q, row_cnt_d;
  logic                cur_null_q, cur_null_d;
  logic                err_q, err_d;

  logic [POS_BITS-1:0] src_p;
  logic [POS_BITS-1:0] next_pos;
  logic [POS_BITS-1:0] cut_val;
  logic [POS_BITS-1:0] ic_cut;
  logic                mismatch;
  logic                open_row;
  logic                valid_cut;
  logic                cut_hit;
  logic                tail_hit;
  group_t              grp;
  logic [CntBits-1:0]  n;

  assign src_p     = POS_BITS'(item_i.src_len);
  assign mismatch  = !item_i.row_null && (item_i.src_len != item_i.split_len);
  assign open_row  = (pos_q != row_end_q);
  assign next_pos  = pos_q + POS_BITS'(1);
  assign valid_cut = item_i.cut_flag && !item_i.cut_null && !cur_null_q;

  // forward cuts close before the element, reverse cuts after it
  assign cut_hit = open_row && valid_cut &&
                   (reverse_mode_i ? (next_pos != row_end_q) : (pos_q != row_start_q));
  assign cut_val  = reverse_mode_i ? next_pos : pos_q;
  assign tail_hit = open_row && (next_pos == row_end_q);
  assign ic_cut   = inner_q + POS_BITS'(cut_hit);

  // result group and next state
  always_comb begin
    n           = '0;
    grp         = '0;
    pos_d       = pos_q;
    row_start_d = row_start_q;
    row_end_d   = row_end_q;
    inner_d     = inner_q;
    row_cnt_d   = row_cnt_q;
    cur_null_d  = cur_null_q;
    err_d       = err_q;
    if (!err_q) begin
      if (item_i.action == ACT_HEADER) begin
        row_cnt_d   = row_cnt_q + RowBits'(1);
        row_start_d = row_end_q;
        pos_d       = row_end_q;
        if (mismatch) begin
          err_d      = 1'b1;
          grp.res[0] = '{kind: KIND_ERROR, value: ValueBits'(row_cnt_q), last: 1'b0};
          n          = CntBits'(1);
        end else begin
          cur_null_d = item_i.row_null;
          row_end_d  = row_end_q + src_p;
          if (src_p == '0) begin
            grp.res[0] = '{kind: KIND_OUTER, value: ValueBits'(inner_q), last: 1'b0};
            n          = CntBits'(1);
          end
        end
      end else if (open_row) begin
        pos_d = next_pos;
        if (cut_hit) begin
          grp.res[0] = '{kind: KIND_INNER, value: ValueBits'(cut_val), last: 1'b0};
          n          = CntBits'(1);
        end
        if (tail_hit) begin
          grp.res[n] = '{kind: KIND_INNER, value: ValueBits'(row_end_q), last: 1'b0};
          grp.res[n + CntBits'(1)] = '{kind: KIND_OUTER,
                                       value: ValueBits'(ic_cut + POS_BITS'(1)),
                                       last: 1'b0};
          n          = n + CntBits'(2);
        end
        inner_d = ic_cut + POS_BITS'(tail_hit);
      end
    end
    if (n != '0) begin
      grp.res[n - CntBits'(1)].last = 1'b1;
    end
    grp.count = n;
  end

  assign group_o    = grp;
  assign stat_o.err = err_q;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      row_start_q <= '0;
      row_end_q   <= '0;
      inner_q     <= '0;
      row_cnt_q   <= '0;
      cur_null_q  <= 1'b0;
      err_q       <= 1'b0;
    end else if (fire_i) begin
      pos_q       <= pos_d;
      row_start_q <= row_start_d;
      row_end_q   <= row_end_d;
      inner_q     <= inner_d;
      row_cnt_q   <= row_cnt_d;
      cur_null_q  <= cur_null_d;
      err_q       <= err_d;
    end
  end

endmodule

// ===== sv/afso_emit.sv =====
// holds one result group; an output register hands it out one item per unstalled cycle
module afso_emit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  afso_pkg::group_t      group_i,
  output afso_pkg::emit_stat_t  stat_o,
  afso_out_if.source            out_o
);
  import afso_pkg::*;

  result_t [MaxRes-1:0] g_q;
  logic [CntBits-1:0]   rem_q, rem_d;
  logic [CntBits-1:0]   head_q, head_d;
  logic                 o_valid_q;
  result_t              o_res_q;
  logic                 o_load;
  logic                 take;
  logic                 new_grp;

  assign o_load  = !o_valid_q || out_o.ready;
  assign take    = o_load && (rem_q != '0);
  assign new_grp = load_i && (group_i.count != '0);

  // group slot frees when its last item moves to the output register
  assign stat_o.ready   = (rem_q == '0) || ((rem_q == CntBits'(1)) && o_load);
  assign stat_o.pending = rem_q;

  always_comb begin
    rem_d  = rem_q;
    head_d = head_q;
    if (take) begin
      rem_d  = rem_q - CntBits'(1);
      head_d = head_q + CntBits'(1);
    end
    if (new_grp) begin
      rem_d  = group_i.count;
      head_d = '0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q     <= '0;
      head_q    <= '0;
      o_valid_q <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      head_q <= head_d;
      if (o_load) begin
        o_valid_q <= (rem_q != '0);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (new_grp) begin
      g_q <= group_i.res;
    end
    if (take) begin
      o_res_q <= g_q[head_q];
    end
  end

  assign out_o.valid = o_valid_q;
  assign out_o.kind  = o_res_q.kind;
  assign out_o.value = o_res_q.value;
  assign out_o.last  = o_res_q.last;

endmodule

// ===== bench/array_flag_split_offsets_tb.sv =====
// self-checking testbench for the array flag split offset generator
`timescale 1ns / 100ps

module array_flag_split_offsets_tb;
  import afso_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 300;
  localparam logic [PaddrBits-1:0] ADDR_REVERSE = PaddrBits'({REG_REVERSE_MODE, 2'b00});

  typedef enum logic [1:0] {
    SINK_FREE,
    SINK_RANDOM,
    SINK_PERIODIC
  } sink_style_e;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PaddrBits-1:0] paddr;
  logic [PdataBits-1:0] pwdata;
  logic [PdataBits-1:0] prdata;
  logic pready;

  afso_in_if  in_ch ();
  afso_out_if out_ch ();

  array_flag_split_offsets i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // items waiting to be offered, and offsets the block still owes
  in_item_t pending_items[$];
  result_t  offsets_due[$];
  int       mismatches;

  // predicted split state
  logic [LenBits-1:0] pos_next;
  logic [LenBits-1:0] seg_start;
  logic [LenBits-1:0] seg_end;
  logic [LenBits-1:0] inner_total;
  logic [RowBits-1:0] row_index;
  logic               row_is_null;
  logic               uneven_seen;
  logic               reverse_cut;

  // sender and receiver behavior knobs
  int          src_gap_max;
  sink_style_e sink_style;
  int          sink_stall_pct;
  int          hold_req;

  // driver and receiver private state
  logic     in_fire;
  in_item_t drv_item;
  int       burst_left;
  int       gap_left;
  int       hold_served;
  int       hold_left;
  int       sink_tick;
  result_t  due_res;

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic result_t offset_res(input kind_e k, input logic [ValueBits-1:0] v);
    offset_res = '{kind: k, value: v, last: 1'b0};
  endfunction

  // element fields of a header are don't-care, so randomize them
  function automatic in_item_t make_header(input logic [LenBits-1:0] src,
                                           input logic [LenBits-1:0] split,
                                           input logic nul);
    make_header = '{action: ACT_HEADER, src_len: src, split_len: split, row_null: nul,
                    cut_flag: 1'($urandom), cut_null: 1'($urandom)};
  endfunction

  // header fields of an element are don't-care, so randomize them
  function automatic in_item_t make_element(input logic flag, input logic cnull);
    make_element = '{action: ACT_ELEMENT, src_len: $urandom, split_len: $urandom,
                     row_null: 1'($urandom), cut_flag: flag, cut_null: cnull};
  endfunction

  // append one item to the driver queue
  task automatic queue_item(input in_item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  // work out the offsets one accepted item causes
  task automatic predict_offsets(input in_item_t it);
    result_t            grp[$];
    logic [LenBits-1:0] nxt;
    logic               cut_ok;
    if (uneven_seen) return;
    if (it.action == ACT_HEADER) begin
      seg_start = seg_end;
      pos_next  = seg_end;
      if (!it.row_null && it.src_len != it.split_len) begin
        uneven_seen = 1'b1;
        grp.insert(grp.size(), offset_res(KIND_ERROR, row_index));
      end else begin
        row_is_null = it.row_null;
        seg_end     = seg_start + it.src_len;
        if (seg_end == seg_start) grp.insert(grp.size(), offset_res(KIND_OUTER, inner_total));
      end
      row_index = row_index + 1'b1;
    end else begin
      // element with no open row is dropped
      if (pos_next == seg_end) return;
      nxt    = pos_next + 1'b1;
      cut_ok = it.cut_flag && !it.cut_null;
      if (!row_is_null && cut_ok) begin
        if (!reverse_cut) begin
          if (pos_next != seg_start) begin
            grp.insert(grp.size(), offset_res(KIND_INNER, pos_next));
            inner_total = inner_total + 1'b1;
          end
        end else if (nxt != seg_end) begin
          grp.insert(grp.size(), offset_res(KIND_INNER, nxt));
          inner_total = inner_total + 1'b1;
        end
      end
      pos_next = nxt;
      // row tail plus the running outer offset
      if (nxt == seg_end) begin
        grp.insert(grp.size(), offset_res(KIND_INNER, seg_end));
        inner_total = inner_total + 1'b1;
        grp.insert(grp.size(), offset_res(KIND_OUTER, inner_total));
      end
    end
    if (grp.size() == 0) return;
    grp[grp.size()-1].last = 1'b1;
    foreach (grp[i]) offsets_due.insert(offsets_due.size(), grp[i]);
  endtask

  // apb write of reverse_mode, then read it back
  task automatic write_reverse(input logic mode);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_REVERSE;
    pwdata  <= {{(PdataBits-1){1'b0}}, mode};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    reverse_cut = mode;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata != {{(PdataBits-1){1'b0}}, mode}) begin
      report_mismatch($sformatf("reverse_mode reads %0h, wrote %0d", prdata, mode));
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // wait until every item went in and every offset came out
  task automatic settle();
    while (pending_items.size() != 0 || in_ch.valid || offsets_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // mostly well-formed rows, with truncated, huge and stray items mixed in
  task automatic queue_random_rows(input int target);
    int                 counted;
    int                 pick;
    int                 len;
    int                 sent;
    logic [LenBits-1:0] span;
    logic               nul;
    counted = 0;
    while (counted < target) begin
      pick = $urandom_range(0, 99);
      nul  = ($urandom_range(0, 5) == 0);
      if (pick < 65) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 14) : $urandom_range(0, 5);
        queue_item(make_header(len, nul ? $urandom : len, nul));
        for (int k = 0; k < len; k++) begin
          queue_item(make_element(1'($urandom), $urandom_range(0, 3) == 0));
        end
        counted += 1 + len;
      end else if (pick < 77) begin
        // row cut short, the next header abandons it
        len  = $urandom_range(2, 8);
        sent = $urandom_range(0, len - 1);
        queue_item(make_header(len, nul ? $urandom : len, nul));
        for (int k = 0; k < sent; k++) begin
          queue_item(make_element(1'($urandom), $urandom_range(0, 3) == 0));
        end
        counted += 1 + sent;
      end else if (pick < 87) begin
        // huge row, positions wrap once it is abandoned
        span = $urandom | 32'h0001_0000;
        sent = $urandom_range(0, 3);
        queue_item(make_header(span, nul ? $urandom : span, nul));
        for (int k = 0; k < sent; k++) begin
          queue_item(make_element(1'($urandom), $urandom_range(0, 3) == 0));
        end
        counted += 1 + sent;
      end else begin
        queue_item(make_element(1'($urandom), 1'($urandom)));
      end
    end
  endtask

  // driver: offers items in bursts with random gaps
  always @(negedge clk_i) begin
    if (!in_ch.valid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        drv_item = pending_items.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.action    <= drv_item.action;
        in_ch.src_len   <= drv_item.src_len;
        in_ch.split_len <= drv_item.split_len;
        in_ch.row_null  <= drv_item.row_null;
        in_ch.cut_flag  <= drv_item.cut_flag;
        in_ch.cut_null  <= drv_item.cut_null;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left   = (src_gap_max == 0) ? 0 : $urandom_range(0, src_gap_max);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern plus an occasional long hold
  always @(negedge clk_i) begin
    sink_tick++;
    if (hold_served != hold_req) begin
      hold_served = hold_req;
      hold_left   = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      case (sink_style)
        SINK_FREE: begin
          out_ch.ready <= 1'b1;
        end
        SINK_RANDOM: begin
          out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
        default: begin
          out_ch.ready <= ((sink_tick % 9) < 5);
        end
      endcase
    end
  end

  // monitor: predict on accepted items, check accepted offsets
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        predict_offsets('{action: in_ch.action, src_len: in_ch.src_len,
                          split_len: in_ch.split_len, row_null: in_ch.row_null,
                          cut_flag: in_ch.cut_flag, cut_null: in_ch.cut_null});
      end
      if (out_ch.valid && out_ch.ready) begin
        if (offsets_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d value %0d last %0d",
                                    out_ch.kind, out_ch.value, out_ch.last));
        end else begin
          due_res = offsets_due.pop_front();
          if (out_ch.kind != due_res.kind) begin
            report_mismatch($sformatf("kind %0d, expected %0d", out_ch.kind, due_res.kind));
          end
          if (out_ch.value != due_res.value) begin
            report_mismatch($sformatf("value %0d, expected %0d (kind %0d)",
                                      out_ch.value, due_res.value, due_res.kind));
          end
          if (out_ch.last != due_res.last) begin
            report_mismatch($sformatf("last %0d, expected %0d (value %0d)",
                                      out_ch.last, due_res.last, due_res.value));
          end
        end
      end
    end
  end

  // stimulus and phase control
  initial begin
    logic [LenBits-1:0] lead;
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.action    = ACT_HEADER;
    in_ch.src_len   = '0;
    in_ch.split_len = '0;
    in_ch.row_null  = 1'b0;
    in_ch.cut_flag  = 1'b0;
    in_ch.cut_null  = 1'b0;
    out_ch.ready    = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_fire         = 1'b0;
    burst_left      = 0;
    gap_left        = 0;
    hold_req        = 0;
    hold_served     = 0;
    hold_left       = 0;
    sink_tick       = 0;
    mismatches      = 0;
    src_gap_max     = 0;
    sink_style      = SINK_FREE;
    sink_stall_pct  = 0;
    pos_next        = '0;
    seg_start       = '0;
    seg_end         = '0;
    inner_total     = '0;
    row_index       = '0;
    row_is_null     = 1'b0;
    uneven_seen     = 1'b0;
    reverse_cut     = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // forward cuts, directed
    write_reverse(1'b0);
    src_gap_max    = 3;
    sink_style     = SINK_RANDOM;
    sink_stall_pct = 30;
    // element before any row is dropped
    queue_item(make_element(1'b1, 1'b0));
    // empty row gives only its outer offset
    queue_item(make_header(0, 0, 1'b0));
    // cut on the first element is ignored, a cut on the last gives three results
    queue_item(make_header(3, 3, 1'b0));
    queue_item(make_element(1'b1, 1'b0));
    queue_item(make_element(1'b0, 1'b0));
    queue_item(make_element(1'b1, 1'b0));
    // null cut flags are ignored
    queue_item(make_header(2, 2, 1'b0));
    queue_item(make_element(1'b1, 1'b1));
    queue_item(make_element(1'b1, 1'b1));
    // null row skips the length check and all cuts
    queue_item(make_header(2, 9, 1'b1));
    queue_item(make_element(1'b1, 1'b0));
    queue_item(make_element(1'b1, 1'b0));
    // all-ones length, abandoned by the next header
    queue_item(make_header('1, '1, 1'b0));
    queue_item(make_element(1'b1, 1'b0));
    queue_item(make_element(1'b0, 1'b0));
    queue_item(make_header(1, 1, 1'b0));
    queue_item(make_element(1'b1, 1'b0));
    settle();
    // park the row end just below the wrap, then a row across zero
    lead = '1 - seg_end;
    queue_item(make_header(lead, lead, 1'b0));
    queue_item(make_header(3, 3, 1'b0));
    queue_item(make_element(1'b1, 1'b0));
    queue_item(make_element(1'b1, 1'b0));
    queue_item(make_element(1'b1, 1'b0));
    settle();

    // forward cuts, random
    src_gap_max    = 6;
    sink_stall_pct = 40;
    queue_random_rows(30);
    settle();

    // reverse cuts: directed, then random behind a long receiver hold
    write_reverse(1'b1);
    queue_item(make_header(3, 3, 1'b0));
    queue_item(make_element(1'b1, 1'b0));
    queue_item(make_element(1'b1, 1'b0));
    queue_item(make_element(1'b1, 1'b0));
    queue_item(make_header(1, 1, 1'b1));
    queue_item(make_element(1'b1, 1'b0));
    settle();
    src_gap_max    = 0;
    sink_stall_pct = 30;
    hold_req++;
    queue_random_rows(30);
    settle();

    // forward cuts with no idling on either side
    write_reverse(1'b0);
    sink_style = SINK_FREE;
    queue_random_rows(25);
    settle();

    // reverse cuts with periodic stalls, then the uneven length error
    write_reverse(1'b1);
    src_gap_max = 10;
    sink_style  = SINK_PERIODIC;
    queue_random_rows(25);
    queue_item(make_header(4, 5, 1'b0));
    // everything after the error is dropped
    queue_item(make_header(2, 2, 1'b0));
    queue_item(make_element(1'b1, 1'b0));
    queue_item(make_element(1'b1, 1'b0));
    queue_item(make_header(0, 0, 1'b0));
    settle();

    if (mismatches == 0) begin
      $display("array_flag_split_offsets_tb OK");
    end else begin
      $display("array_flag_split_offsets_tb NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("array_flag_split_offsets_tb NOT OK");
    $finish;
  end

endmodule
